>>> hdl/vpy_pkg.sv
// Package for the vector to pitch/yaw block: widths, fixed constants,
// pipeline payload types and the CORDIC arctangent table.
// No dependencies.
package vpy_pkg;

   localparam int VEC_W    = 32;  // input component width, signed Q16.16
   localparam int ANG_W    = 25;  // output angle width, unsigned Q9.16
   localparam int BAM_W    = 32;  // binary angle, 2^32 per full turn
   localparam int IN_SHIFT = 28;  // Q16.16 -> Q16.44 inside the CORDIC
   localparam int CW       = 63;  // CORDIC datapath width, signed
   localparam int KGAIN_W  = 31;
   localparam int DEG_FULL = 360;
   localparam int DEG_UP   = 270; // pitch when straight up the z axis
   localparam int DEG_DOWN = 90;  // pitch for the other vertical case

   // CORDIC gain limit, 1.6467602581 in Q1.30
   localparam logic [KGAIN_W-1:0] KGAIN    = 31'd1768195364;
   localparam logic [BAM_W-1:0]   BAM_HALF = 32'h8000_0000;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [BAM_W-1:0]     a;
   } cordic_type;

   typedef struct packed {
      logic signed [CW-1:0] zprod;    // z * KGAIN, consumed at the handoff
      logic [BAM_W-1:0]     yaw_bam;  // yaw angle, carried through pitch run
      logic                 vertical; // x and y both zero
      logic                 z_pos;    // z greater than zero
   } side_type;

   typedef struct packed {
      logic [ANG_W-1:0] pitch_deg;
      logic [ANG_W-1:0] yaw_deg;
      logic             vertical_case;
   } result_type;

   // atan(2^-idx) in binary angle units
   function automatic logic [BAM_W-1:0] atan_bam(input logic [4:0] idx);
      logic [BAM_W-1:0] v;
      case (idx)
         5'd0:  v = 32'h2000_0000;
         5'd1:  v = 32'h12E4_051E;
         5'd2:  v = 32'h09FB_385B;
         5'd3:  v = 32'h0511_11D4;
         5'd4:  v = 32'h028B_0D43;
         5'd5:  v = 32'h0145_D7E1;
         5'd6:  v = 32'h00A2_F61E;
         5'd7:  v = 32'h0051_7C55;
         5'd8:  v = 32'h0028_BE53;
         5'd9:  v = 32'h0014_5F2F;
         5'd10: v = 32'h000A_2F98;
         5'd11: v = 32'h0005_17CC;
         5'd12: v = 32'h0002_8BE6;
         5'd13: v = 32'h0001_45F3;
         5'd14: v = 32'h0000_A2FA;
         5'd15: v = 32'h0000_517D;
         5'd16: v = 32'h0000_28BE;
         5'd17: v = 32'h0000_145F;
         5'd18: v = 32'h0000_0A30;
         5'd19: v = 32'h0000_0518;
         5'd20: v = 32'h0000_028C;
         5'd21: v = 32'h0000_0146;
         5'd22: v = 32'h0000_00A3;
         5'd23: v = 32'h0000_0051;
         5'd24: v = 32'h0000_0029;
         5'd25: v = 32'h0000_0014;
         5'd26: v = 32'h0000_000A;
         5'd27: v = 32'h0000_0005;
         5'd28: v = 32'h0000_0003;
         5'd29: v = 32'h0000_0001;
         5'd30: v = 32'h0000_0001;
         5'd31: v = 32'h0000_0000;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/vpy_req_if.sv
// Request channel interface: valid/ready handshake plus the direction vector.
// Depends on vpy_pkg for widths.
interface vpy_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [vpy_pkg::VEC_W-1:0] vec_x;
   logic signed [vpy_pkg::VEC_W-1:0] vec_y;
   logic signed [vpy_pkg::VEC_W-1:0] vec_z;

   modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
   modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

>>> hdl/vpy_rsp_if.sv
// Response channel interface: valid/ready handshake plus pitch, yaw and flag.
// Depends on vpy_pkg for widths.
interface vpy_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [vpy_pkg::ANG_W-1:0] pitch_deg;
   logic [vpy_pkg::ANG_W-1:0] yaw_deg;
   logic                      vertical_case;

   modport source (output valid, output pitch_deg, output yaw_deg, output vertical_case,
                   input ready);
   modport sink   (input valid, input pitch_deg, input yaw_deg, input vertical_case,
                   output ready);
endinterface

>>> hdl/vpy_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation with a sideband that rides along.
// Depends on vpy_pkg (cordic_type, side_type, atan_bam).
module vpy_cordic_stage #(
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 up_valid,
   input  vpy_pkg::cordic_type  up_data,
   input  vpy_pkg::side_type    up_side,
   output logic                 dn_valid,
   output vpy_pkg::cordic_type  dn_data,
   output vpy_pkg::side_type    dn_side
);

   localparam logic [vpy_pkg::BAM_W-1:0] STEP = vpy_pkg::atan_bam(5'(SHIFT));

   logic signed [vpy_pkg::CW-1:0] dx;
   logic signed [vpy_pkg::CW-1:0] dy;
   vpy_pkg::cordic_type           data_in;
   vpy_pkg::cordic_type           data_ff;
   vpy_pkg::side_type             side_ff;
   logic                          valid_ff;

   // rotate toward the x axis; y of zero rotates clockwise
   always_comb begin
      dx = $signed(up_data.y) >>> SHIFT;
      dy = $signed(up_data.x) >>> SHIFT;
      if (!up_data.y[vpy_pkg::CW-1]) begin
         data_in.x = up_data.x + dx;
         data_in.y = up_data.y - dy;
         data_in.a = up_data.a + STEP;
      end else begin
         data_in.x = up_data.x - dx;
         data_in.y = up_data.y + dy;
         data_in.a = up_data.a - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;
   assign dn_side  = side_ff;

endmodule

>>> hdl/vector_to_pitch_yaw.sv
// Top level: direction vector (Q16.16) to pitch and yaw in degrees (Q9.16).
// Depends on vpy_pkg, vpy_req_if, vpy_rsp_if and vpy_cordic_stage.
//
//   channel   iface        direction  payload
//   req_ch    vpy_req_if   in         vec_x, vec_y, vec_z (signed Q16.16)
//   rsp_ch    vpy_rsp_if   out        pitch_deg, yaw_deg (Q9.16), vertical_case
//
// One vector per cycle sustained while rsp stays ready. From req transfer to rsp
// valid an item passes the entry stage, yaw CORDIC stages, handoff stage,
// pitch CORDIC stages, degree scaling stage and output register.
// Synchronous reset clears only the valid bits of every stage and the output.
// A stalled rsp first fills a one-entry skid register; ready drops only
// while the skid holds an item, and then the whole pipeline holds.
module vector_to_pitch_yaw #(
   parameter int CORDIC_STAGES = 20,
   parameter int FRAC_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   vpy_req_if.sink     req_ch,
   vpy_rsp_if.source   rsp_ch
);

   localparam int N      = CORDIC_STAGES;
   localparam int DEG_W  = 9 + FRAC_BITS;           // holds 0..360 in output format
   localparam int PROD_W = vpy_pkg::BAM_W + 9;      // binary angle times 360
   localparam int DROP   = vpy_pkg::BAM_W - FRAC_BITS;
   localparam logic [PROD_W-1:0] RND      = PROD_W'(1) << (DROP - 1);
   localparam logic [PROD_W-1:0] MUL_360  = PROD_W'(vpy_pkg::DEG_FULL);
   localparam logic [DEG_W-1:0]  FULL_DEG = DEG_W'(vpy_pkg::DEG_FULL) << FRAC_BITS;
   localparam logic [DEG_W-1:0]  UP_DEG   = DEG_W'(vpy_pkg::DEG_UP) << FRAC_BITS;
   localparam logic [DEG_W-1:0]  DOWN_DEG = DEG_W'(vpy_pkg::DEG_DOWN) << FRAC_BITS;
   localparam int IN_W = vpy_pkg::VEC_W + vpy_pkg::IN_SHIFT;

   // Drop the rounding bits and wrap a result that rounded up to a full turn.
   function automatic logic [DEG_W-1:0] bam_deg(input logic [PROD_W-1:0] prod);
      logic [DEG_W-1:0] d;
      d = DEG_W'(prod >> DROP);
      if (d >= FULL_DEG) begin
         d = d - FULL_DEG;
      end
      return d;
   endfunction

   // Fit a degree value to the output field: truncate or zero-extend.
   function automatic logic [vpy_pkg::ANG_W-1:0] to_ang(input logic [DEG_W-1:0] d);
      logic [DEG_W+vpy_pkg::ANG_W-1:0] ext;
      ext = {{vpy_pkg::ANG_W{1'b0}}, d};
      return ext[vpy_pkg::ANG_W-1:0];
   endfunction

   // Pipeline-wide advance; held only while the skid register is occupied
   logic en;

   // Entry stage
   logic signed [IN_W-1:0]          xs_wide;
   logic signed [IN_W-1:0]          ys_wide;
   logic signed [vpy_pkg::CW-1:0]   xs;
   logic signed [vpy_pkg::CW-1:0]   ys;
   logic signed [2*vpy_pkg::VEC_W-1:0] zprod_full;
   vpy_pkg::cordic_type             entry_data_in;
   vpy_pkg::side_type               entry_side_in;

   // Yaw run, index 0 is the entry register
   logic                  yaw_v [0:N];
   vpy_pkg::cordic_type   yaw_d [0:N];
   vpy_pkg::side_type     yaw_s [0:N];

   // Pitch run, index 0 is the handoff register
   logic                  pit_v [0:N];
   vpy_pkg::cordic_type   pit_d [0:N];
   vpy_pkg::side_type     pit_s [0:N];

   logic signed [vpy_pkg::CW-1:0] neg_zprod;
   vpy_pkg::cordic_type           hand_data_in;
   vpy_pkg::side_type             hand_side_in;

   // Degree scaling stage
   logic              conv_valid_ff;
   logic [PROD_W-1:0] conv_yaw_ff;
   logic [PROD_W-1:0] conv_pit_ff;
   logic              conv_vert_ff;
   logic              conv_zpos_ff;
   vpy_pkg::result_type result;

   // Output register and skid
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   vpy_pkg::result_type rsp_data_ff;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   vpy_pkg::result_type skid_data_ff;
   logic                take;
   logic                arrive;
   logic                load_rsp_pipe;
   logic                load_rsp_skid;
   logic                load_skid;

   assign en           = !skid_valid_ff;
   assign req_ch.ready = en;

   // ---------------------------------------------------------------- entry
   // Scale to Q16.44, fold the left half plane onto the right one (start at
   // a half turn), and form z times the gain for the pitch run.
   always_comb begin
      xs_wide    = {req_ch.vec_x, {vpy_pkg::IN_SHIFT{1'b0}}};
      ys_wide    = {req_ch.vec_y, {vpy_pkg::IN_SHIFT{1'b0}}};
      xs         = vpy_pkg::CW'(xs_wide);
      ys         = vpy_pkg::CW'(ys_wide);
      zprod_full = (2*vpy_pkg::VEC_W)'(req_ch.vec_z)
                 * (2*vpy_pkg::VEC_W)'($signed({1'b0, vpy_pkg::KGAIN}));
      if (req_ch.vec_x[vpy_pkg::VEC_W-1]) begin
         entry_data_in.x = -xs;
         entry_data_in.y = -ys;
         entry_data_in.a = vpy_pkg::BAM_HALF;
      end else begin
         entry_data_in.x = xs;
         entry_data_in.y = ys;
         entry_data_in.a = '0;
      end
      entry_side_in.zprod    = $signed(zprod_full[vpy_pkg::CW-1:0]);
      entry_side_in.yaw_bam  = '0;
      entry_side_in.vertical = (req_ch.vec_x == '0) && (req_ch.vec_y == '0);
      entry_side_in.z_pos    = (req_ch.vec_z > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_v[0] <= 1'b0;
      end else if (en) begin
         yaw_v[0] <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_d[0] <= entry_data_in;
         yaw_s[0] <= entry_side_in;
      end
   end

   // ---------------------------------------------------------------- yaw run
   for (genvar k = 0; k < N; k++) begin : g_yaw
      vpy_cordic_stage #(.SHIFT(k)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (yaw_v[k]),
         .up_data  (yaw_d[k]),
         .up_side  (yaw_s[k]),
         .dn_valid (yaw_v[k+1]),
         .dn_data  (yaw_d[k+1]),
         .dn_side  (yaw_s[k+1])
      );
   end

   // ---------------------------------------------------------------- handoff
   // The yaw run's x is K times the horizontal length and never negative
   // (x only grows in vectoring), so the pitch run needs no fold.
   always_comb begin
      neg_zprod              = -yaw_s[N].zprod;
      hand_data_in.x         = yaw_d[N].x;
      hand_data_in.y         = neg_zprod >>> 2;
      hand_data_in.a         = '0;
      hand_side_in.zprod     = '0;
      hand_side_in.yaw_bam   = yaw_d[N].a;
      hand_side_in.vertical  = yaw_s[N].vertical;
      hand_side_in.z_pos     = yaw_s[N].z_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pit_v[0] <= 1'b0;
      end else if (en) begin
         pit_v[0] <= yaw_v[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pit_d[0] <= hand_data_in;
         pit_s[0] <= hand_side_in;
      end
   end

   // ---------------------------------------------------------------- pitch run
   for (genvar k = 0; k < N; k++) begin : g_pitch
      vpy_cordic_stage #(.SHIFT(k)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (pit_v[k]),
         .up_data  (pit_d[k]),
         .up_side  (pit_s[k]),
         .dn_valid (pit_v[k+1]),
         .dn_data  (pit_d[k+1]),
         .dn_side  (pit_s[k+1])
      );
   end

   // ---------------------------------------------------------------- scaling
   // Binary angle times 360 plus half an output LSB; the shift follows.
   always_ff @(posedge clock) begin
      if (reset) begin
         conv_valid_ff <= 1'b0;
      end else if (en) begin
         conv_valid_ff <= pit_v[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         conv_yaw_ff  <= PROD_W'(pit_s[N].yaw_bam) * MUL_360 + RND;
         conv_pit_ff  <= PROD_W'(pit_d[N].a) * MUL_360 + RND;
         conv_vert_ff <= pit_s[N].vertical;
         conv_zpos_ff <= pit_s[N].z_pos;
      end
   end

   // Vertical vector: yaw is zero, pitch points straight up or down.
   always_comb begin
      result.vertical_case = conv_vert_ff;
      if (conv_vert_ff) begin
         result.yaw_deg   = '0;
         result.pitch_deg = to_ang(conv_zpos_ff ? UP_DEG : DOWN_DEG);
      end else begin
         result.yaw_deg   = to_ang(bam_deg(conv_yaw_ff));
         result.pitch_deg = to_ang(bam_deg(conv_pit_ff));
      end
   end

   // ---------------------------------------------------------------- output
   // The skid drains first; a new result goes to the output register when it
   // is free or being transferred this cycle, otherwise into the skid.
   always_comb begin
      take          = rsp_valid_ff && rsp_ch.ready;
      arrive        = en && conv_valid_ff;
      load_rsp_skid = (!rsp_valid_ff || take) && skid_valid_ff;
      load_rsp_pipe = (!rsp_valid_ff || take) && !skid_valid_ff && arrive;
      load_skid     = rsp_valid_ff && !take && arrive;
      rsp_valid_in  = (rsp_valid_ff && !take) || load_rsp_skid || load_rsp_pipe;
      skid_valid_in = (skid_valid_ff && !load_rsp_skid) || load_skid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp_skid) begin
         rsp_data_ff <= skid_data_ff;
      end else if (load_rsp_pipe) begin
         rsp_data_ff <= result;
      end
      if (load_skid) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pitch_deg     = rsp_data_ff.pitch_deg;
   assign rsp_ch.yaw_deg       = rsp_data_ff.yaw_deg;
   assign rsp_ch.vertical_case = rsp_data_ff.vertical_case;

`ifndef SYNTHESIS
   // skid only fills behind a waiting output
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while the output register is empty");

   // a result arriving at a stalled, full output must land in the skid
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (arrive && rsp_valid_ff && !rsp_ch.ready) |=> skid_valid_ff)
      else $error("result dropped at a stalled output");

   // skid contents hold until drained
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !take) |=> (skid_valid_ff && $stable(skid_data_ff)))
      else $error("skid changed while the output was stalled");

   // vertical vectors report zero yaw
   a_vertical_yaw: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.vertical_case) |-> (rsp_ch.yaw_deg == '0))
      else $error("vertical case with nonzero yaw");
`endif

endmodule

>>> sim/vpy_angle_checker.sv
`timescale 1ns / 1ps
// Scoreboard for vector_to_pitch_yaw: predicts pitch, yaw and the vertical flag
// for every request transfer and checks each response transfer in order.
// Depends on vpy_pkg, vpy_req_if and vpy_rsp_if.
module vpy_angle_checker #(
   parameter int CORDIC_STAGES = 20,
   parameter int FRAC_BITS     = 16
) (
   input  logic clock,
   input  logic reset,
   vpy_req_if   req_mon,
   vpy_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked,
   output int   vertical_seen
);

   localparam longint GAIN_Q30 = 64'sd1768195364;

   // atan(2^-i) in turn units of 2^32, entry i sits at [i]
   localparam logic [31:0][31:0] ATAN_TURN = {
      32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 32'h0000_0003,
      32'h0000_0005, 32'h0000_000A, 32'h0000_0014, 32'h0000_0029,
      32'h0000_0051, 32'h0000_00A3, 32'h0000_0146, 32'h0000_028C,
      32'h0000_0518, 32'h0000_0A30, 32'h0000_145F, 32'h0000_28BE,
      32'h0000_517D, 32'h0000_A2FA, 32'h0001_45F3, 32'h0002_8BE6,
      32'h0005_17CC, 32'h000A_2F98, 32'h0014_5F2F, 32'h0028_BE53,
      32'h0051_7C55, 32'h00A2_F61E, 32'h0145_D7E1, 32'h028B_0D43,
      32'h0511_11D4, 32'h09FB_385B, 32'h12E4_051E, 32'h2000_0000
   };

   vpy_pkg::result_type expected_angles[$];

   // Rotate (x, y) onto the positive x axis; return the angle, leave K*length in len.
   function automatic logic [31:0] vector_angle(input longint x_in, input longint y_in,
                                                output longint len);
      longint           xs, ys, dx, dy;
      logic [31:0]      ang;
      xs  = x_in;
      ys  = y_in;
      ang = 32'h0;
      if (xs < 0) begin
         xs  = -xs;
         ys  = -ys;
         ang = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         dx = ys >>> i;
         dy = xs >>> i;
         if (ys >= 0) begin
            xs  = xs + dx;
            ys  = ys - dy;
            ang = ang + ATAN_TURN[i];
         end else begin
            xs  = xs - dx;
            ys  = ys + dy;
            ang = ang - ATAN_TURN[i];
         end
      end
      len = xs;
      return ang;
   endfunction

   // Turn units to degrees with round half up; wrap a full turn to zero.
   function automatic logic [vpy_pkg::ANG_W-1:0] turn_to_degrees(input logic [31:0] ang);
      logic [63:0] full, d;
      full = 64'd360 << FRAC_BITS;
      d = ({32'd0, ang} * 64'd360 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
      if (d >= full)
         d = d - full;
      return d[vpy_pkg::ANG_W-1:0];
   endfunction

   function automatic vpy_pkg::result_type predict_angles(input logic signed [31:0] vx,
                                                          input logic signed [31:0] vy,
                                                          input logic signed [31:0] vz);
      longint              x, y, z, hlen, spare, zk;
      logic [63:0]         straight;
      vpy_pkg::result_type r;
      x = longint'(vx);
      y = longint'(vy);
      z = longint'(vz);
      if (x == 0 && y == 0) begin
         straight        = (z > 0) ? (64'd270 << FRAC_BITS) : (64'd90 << FRAC_BITS);
         r.pitch_deg     = straight[vpy_pkg::ANG_W-1:0];
         r.yaw_deg       = '0;
         r.vertical_case = 1'b1;
      end else begin
         r.yaw_deg       = turn_to_degrees(vector_angle(x <<< 28, y <<< 28, hlen));
         zk              = ((-z) * GAIN_Q30) >>> 2;
         r.pitch_deg     = turn_to_degrees(vector_angle(hlen, zk, spare));
         r.vertical_case = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      vpy_pkg::result_type want, got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            expected_angles.push_back(predict_angles(req_mon.vec_x, req_mon.vec_y,
                                                     req_mon.vec_z));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.pitch_deg     = rsp_mon.pitch_deg;
            got.yaw_deg       = rsp_mon.yaw_deg;
            got.vertical_case = rsp_mon.vertical_case;
            if (expected_angles.size() == 0) begin
               $display("%0t: unexpected response pitch %0d yaw %0d vertical %0b",
                        $time, got.pitch_deg, got.yaw_deg, got.vertical_case);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_angles.pop_front();
               if (got !== want) begin
                  $display("%0t: exp pitch %0d yaw %0d vert %0b, got pitch %0d yaw %0d vert %0b",
                           $time, want.pitch_deg, want.yaw_deg, want.vertical_case,
                           got.pitch_deg, got.yaw_deg, got.vertical_case);
                  fail_count <= fail_count + 1;
               end
               checked <= checked + 1;
               if (got.vertical_case)
                  vertical_seen <= vertical_seen + 1;
            end
         end
      end
      pending <= expected_angles.size();
   end

endmodule

>>> sim/tb_vector_to_pitch_yaw.sv
`timescale 1ns / 1ps
// Testbench top for vector_to_pitch_yaw: drives direction vectors, throttles the
// response side and reports the verdict. Depends on vpy_pkg, the two channel
// interfaces, the block itself and vpy_angle_checker.
module tb_vector_to_pitch_yaw;

   localparam int CORDIC_STAGES = 20;
   localparam int FRAC_BITS     = 16;
   localparam int LATENCY       = 2 * CORDIC_STAGES + 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 400;

   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] NEG_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE     = 32'sh0001_0000;  // 1.0 in Q16.16

   logic clock;
   logic reset;
   logic jitter_on;        // random idle cycles on both sides when set
   int   cycle_count;
   int   sent;
   int   directed;
   int   fail_count, pending, checked, vertical_seen;

   vpy_req_if req_ch ();
   vpy_rsp_if rsp_ch ();

   vector_to_pitch_yaw #(
      .CORDIC_STAGES(CORDIC_STAGES),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   vpy_angle_checker #(
      .CORDIC_STAGES(CORDIC_STAGES),
      .FRAC_BITS    (FRAC_BITS)
   ) u_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked),
      .vertical_seen(vertical_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d results outstanding", $time, pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side: drop ready at random, with a chance of one in ten, while jitter is on.
   always @(posedge clock) begin
      rsp_ch.ready <= !jitter_on || ($urandom_range(0, 99) >= 10);
   end

   // Offer one vector and hold it until the block takes it. Valid is left high;
   // the next call either replaces the payload or lowers valid for a gap.
   task automatic send_vector(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z);
      while (jitter_on && $urandom_range(0, 99) < 10) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.vec_x <= x;
      req_ch.vec_y <= y;
      req_ch.vec_z <= z;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      sent++;
   endtask

   // Hold off the sender until every predicted result has been transferred.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending != 0);
   endtask

   // Mix full-range words with small, axis-aligned and extreme components so the
   // CORDIC sees both tiny and near-overflow magnitudes.
   function automatic logic signed [31:0] random_component();
      logic signed [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return w;
         4, 5:       return $signed($urandom_range(0, 131072)) - 32'sd65536;
         6:          return '0;
         7: begin
            case ($urandom_range(0, 3))
               0:       return POS_MAX;
               1:       return NEG_MIN;
               2:       return 32'sd1;
               default: return -32'sd1;
            endcase
         end
         8:          return ($urandom_range(0, 1) ? ONE : -ONE) * $urandom_range(1, 100);
         default:    return w >>> $urandom_range(1, 30);
      endcase
   endfunction

   task automatic send_random(input int count);
      logic signed [31:0] x, y, z;
      repeat (count) begin
         x = random_component();
         y = random_component();
         z = random_component();
         // force the straight up/down case now and then
         if ($urandom_range(0, 99) < 8) begin
            x = '0;
            y = '0;
         end
         send_vector(x, y, z);
      end
   endtask

   initial begin
      reset        <= 1'b1;
      jitter_on    <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.vec_x <= '0;
      req_ch.vec_y <= '0;
      req_ch.vec_z <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: axes, quadrants, near-wrap angles and the vertical cases.
      send_vector(ONE, 0, 0);            // zero y at the CORDIC input
      send_vector(0, ONE, 0);
      send_vector(-ONE, 0, 0);           // negative x, half-turn start
      send_vector(0, -ONE, 0);
      send_vector(ONE, -32'sd1, 0);      // yaw just below a full turn
      send_vector(POS_MAX, -32'sd1, 0);
      send_vector(ONE, 0, 32'sd1);       // pitch just below a full turn
      send_vector(ONE, 0, -ONE);
      send_vector(0, 0, 0);              // vertical, z zero
      send_vector(0, 0, 32'sd1);         // vertical, z positive
      send_vector(0, 0, -32'sd1);
      send_vector(0, 0, POS_MAX);
      send_vector(0, 0, NEG_MIN);
      send_vector(POS_MAX, POS_MAX, POS_MAX);
      send_vector(NEG_MIN, NEG_MIN, NEG_MIN);
      send_vector(NEG_MIN, 0, 0);
      send_vector(0, NEG_MIN, 0);
      send_vector(POS_MAX, NEG_MIN, 0);
      send_vector(32'sd1, 0, 0);
      send_vector(-32'sd1, -32'sd1, NEG_MIN);
      send_vector(NEG_MIN, -32'sd1, 0);  // just past a half turn
      send_vector(32'sd1, 0, NEG_MIN);   // pitch near a quarter turn
      directed = sent;

      // Pause the sender once with the pipeline full of directed work.
      wait_for_drain();

      send_random(RANDOM_ITEMS * 3 / 10);

      // Long stretch at full rate on both sides.
      jitter_on <= 1'b0;
      send_random(RANDOM_ITEMS * 4 / 10);
      jitter_on <= 1'b1;
      wait_for_drain();

      send_random(RANDOM_ITEMS - RANDOM_ITEMS * 3 / 10 - RANDOM_ITEMS * 4 / 10);

      wait_for_drain();
      repeat (LATENCY + 8) @(posedge clock);

      $display("Sent %0d vectors (%0d directed), checked %0d results, %0d on the z axis",
               sent, directed, checked, vertical_seen);
      $display("Mismatches: %0d, results still outstanding: %0d", fail_count, pending);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> sim.f
hdl/vpy_pkg.sv
hdl/vpy_req_if.sv
hdl/vpy_rsp_if.sv
hdl/vpy_cordic_stage.sv
hdl/vector_to_pitch_yaw.sv
sim/vpy_angle_checker.sv
sim/tb_vector_to_pitch_yaw.sv
